// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/psk_pkg.sv =====
`default_nettype none

package psk_pkg;

  localparam int unsigned DEPTH_W = 11;

  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_POP   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OUT_ZERO = 2'd0,
    OUT_NODE = 2'd1,
    OUT_PUSH = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    VS_BASE = 2'd0,
    VS_NEW  = 2'd1,
    VS_NONE = 2'd2
  } ver_sel_e;

  typedef enum logic {
    NS_HEAD = 1'b0,
    NS_LINK = 1'b1
  } node_sel_e;

  typedef struct packed {
    logic      latch;
    logic      clear;
    logic      head_rd;
    logic      node_rd;
    node_sel_e node_sel;
    logic      push_wr;
    logic      pop_wr;
    logic      out_load;
    out_kind_e kind;
    ver_sel_e  ver_sel;
    status_e   status;
  } psk_cmd_t;

  typedef struct packed {
    logic unknown_in;
    logic head_null;
    logic link_null;
    logic vc_full;
    logic nc_full;
    logic out_free;
  } psk_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psk_ram.sv =====
`default_nettype none

module psk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/psk_ctrl.sv =====
`default_nettype none

module psk_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire psk_pkg::mode_e     mode_i,
  output logic                    in_ready_o,
  input  wire psk_pkg::psk_stat_t stat_i,
  output psk_pkg::psk_cmd_t       cmd_o
);

  import psk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_LINK = 5'b00100,
    S_DEP  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e    state_q, state_d;
  mode_e     mode_q, mode_d;
  out_kind_e kind_q, kind_d;
  ver_sel_e  vs_q, vs_d;
  status_e   st_q, st_d;

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    kind_d         = kind_q;
    vs_d           = vs_q;
    st_d           = st_q;
    cmd_o          = '0;
    cmd_o.node_sel = NS_HEAD;
    cmd_o.kind     = kind_q;
    cmd_o.ver_sel  = vs_q;
    cmd_o.status   = st_q;
    in_ready_o     = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          mode_d      = mode_i;
          if (mode_i == MODE_CLEAR) begin
            cmd_o.clear = 1'b1;
            kind_d      = OUT_ZERO;
            vs_d        = VS_NONE;
            st_d        = ST_OK;
            state_d     = S_OUT;
          end else if (stat_i.unknown_in) begin
            kind_d  = OUT_ZERO;
            vs_d    = VS_BASE;
            st_d    = ST_UNKNOWN;
            state_d = S_OUT;
          end else begin
            cmd_o.head_rd = 1'b1;
            state_d       = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        vs_d    = VS_BASE;
        kind_d  = OUT_NODE;
        st_d    = ST_OK;
        state_d = S_OUT;
        if (mode_q == MODE_PUSH) begin
          if (stat_i.vc_full || stat_i.nc_full) begin
            st_d = ST_FULL;
            if (stat_i.head_null) begin
              kind_d = OUT_ZERO;
            end else begin
              cmd_o.node_rd = 1'b1;
            end
          end else if (stat_i.head_null) begin
            cmd_o.push_wr = 1'b1;
            kind_d        = OUT_PUSH;
            vs_d          = VS_NEW;
          end else begin
            cmd_o.node_rd = 1'b1;
            state_d       = S_DEP;
          end
        end else if (stat_i.head_null) begin
          kind_d = OUT_ZERO;
          st_d   = ST_EMPTY;
        end else if (mode_q == MODE_POP && !stat_i.vc_full) begin
          cmd_o.node_rd = 1'b1;
          state_d       = S_LINK;
        end else begin
          cmd_o.node_rd = 1'b1;
          if (mode_q == MODE_POP) begin
            st_d = ST_FULL;
          end
        end
      end
      S_LINK: begin
        cmd_o.pop_wr = 1'b1;
        vs_d         = VS_NEW;
        st_d         = ST_OK;
        state_d      = S_OUT;
        if (stat_i.link_null) begin
          kind_d = OUT_ZERO;
        end else begin
          cmd_o.node_rd  = 1'b1;
          cmd_o.node_sel = NS_LINK;
          kind_d         = OUT_NODE;
        end
      end
      S_DEP: begin
        cmd_o.push_wr = 1'b1;
        kind_d        = OUT_PUSH;
        vs_d          = VS_NEW;
        st_d          = ST_OK;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_QUERY;
      kind_q  <= OUT_ZERO;
      vs_q    <= VS_NONE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      kind_q  <= kind_d;
      vs_q    <= vs_d;
      st_q    <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/psk_dpath.sv =====
`default_nettype none

module psk_dpath #(
  parameter int unsigned MAX_VERSIONS = 1024,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [9:0]          version_i,
  input  wire logic signed [31:0]  push_value_i,
  input  wire psk_pkg::psk_cmd_t   cmd_i,
  output psk_pkg::psk_stat_t       stat_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [9:0]               result_version_o,
  output logic signed [31:0]       top_value_o,
  output logic [9:0]               depth_o,
  output logic                     is_empty_o,
  output logic [1:0]               status_o
);

  import psk_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_VERSIONS);
  localparam int unsigned PW   = AW + 1;
  localparam int unsigned CMPW = (PW > 10) ? PW : 10;
  localparam int unsigned NW   = VALUE_WIDTH + PW + DEPTH_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(MAX_VERSIONS);

  logic [9:0]             ver_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [PW-1:0]          vc_q, nc_q;
  logic [DEPTH_W-1:0]     push_depth_q;
  logic                   out_valid_q;
  logic [9:0]             res_ver_q;
  logic [31:0]            top_q;
  logic [9:0]             depth_q;
  logic                   empty_q;
  logic [1:0]             status_q;

  logic [PW-1:0]          head_rdata, head_eff, head_wdata;
  logic [NW-1:0]          node_rdata, node_wdata;
  logic [VALUE_WIDTH-1:0] node_value;
  logic [PW-1:0]          node_link;
  logic [DEPTH_W-1:0]     node_depth, new_depth;
  logic [AW-1:0]          node_raddr;
  logic                   head_null;

  assign node_value = node_rdata[NW-1 -: VALUE_WIDTH];
  assign node_link  = node_rdata[DEPTH_W +: PW];
  assign node_depth = node_rdata[DEPTH_W-1:0];

  // version 0 is never written and always empty
  assign head_eff   = (ver_q == 10'd0) ? NULL_PTR : head_rdata;
  assign head_null  = (head_eff == NULL_PTR);
  assign new_depth  = head_null ? DEPTH_W'(1) : node_depth + DEPTH_W'(1);
  assign head_wdata = cmd_i.push_wr ? nc_q : node_link;
  assign node_wdata = {val_q, head_eff, new_depth};
  assign node_raddr = (cmd_i.node_sel == NS_LINK) ? AW'(node_link) : AW'(head_eff);

  psk_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_VERSIONS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr | cmd_i.pop_wr),
    .waddr_i (AW'(vc_q)),
    .wdata_i (head_wdata),
    .re_i    (cmd_i.head_rd),
    .raddr_i (AW'(version_i)),
    .rdata_o (head_rdata)
  );

  psk_ram #(
    .WIDTH(NW),
    .DEPTH(MAX_VERSIONS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr),
    .waddr_i (AW'(nc_q)),
    .wdata_i (node_wdata),
    .re_i    (cmd_i.node_rd),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  assign stat_o.unknown_in = (CMPW'(version_i) >= CMPW'(vc_q));
  assign stat_o.head_null  = head_null;
  assign stat_o.link_null  = (node_link == NULL_PTR);
  assign stat_o.vc_full    = (vc_q == NULL_PTR);
  assign stat_o.nc_full    = (nc_q == NULL_PTR);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ver_q <= version_i;
      val_q <= VALUE_WIDTH'($unsigned(push_value_i));
    end
    if (cmd_i.push_wr) begin
      push_depth_q <= new_depth;
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.status;
      case (cmd_i.ver_sel)
        VS_BASE: res_ver_q <= ver_q;
        VS_NEW:  res_ver_q <= 10'(vc_q - PW'(1));
        default: res_ver_q <= 10'd0;
      endcase
      case (cmd_i.kind)
        OUT_NODE: begin
          top_q   <= 32'(node_value);
          depth_q <= 10'(node_depth);
          empty_q <= (node_depth == '0);
        end
        OUT_PUSH: begin
          top_q   <= 32'(val_q);
          depth_q <= 10'(push_depth_q);
          empty_q <= (push_depth_q == '0);
        end
        default: begin
          top_q   <= 32'd0;
          depth_q <= 10'd0;
          empty_q <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= PW'(1);
      nc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        vc_q <= PW'(1);
        nc_q <= '0;
      end else if (cmd_i.push_wr) begin
        vc_q <= vc_q + PW'(1);
        nc_q <= nc_q + PW'(1);
      end else if (cmd_i.pop_wr) begin
        vc_q <= vc_q + PW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_version_o = res_ver_q;
  assign top_value_o      = top_q;
  assign depth_o          = depth_q;
  assign is_empty_o       = empty_q;
  assign status_o         = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/persistent_stack_engine.sv =====
// after accept, clear and an unknown version go straight to the output state; query,
// push on an empty base and a push or pop that fails pass the version table read first,
// and push on a non-empty base and a pop that appends a version pass a node pool step too
// one item at a time, its steps plus output wait; the steps are set by the
// dependent registered reads of the version table and then the node pool
// reset: one version (empty version 0) and no nodes; tables are not cleared,
// version 0 decodes as empty, so the block takes items right after reset
`default_nettype none

module persistent_stack_engine #(
  parameter int unsigned MAX_VERSIONS = 1024,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [9:0]         version_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [9:0]              result_version_o,
  output logic signed [31:0]      top_value_o,
  output logic [9:0]              depth_o,
  output logic                    is_empty_o,
  output logic [1:0]              status_o
);

  import psk_pkg::*;

  psk_cmd_t  cmd;
  psk_stat_t stat;

  psk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_e'(mode_i)),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psk_dpath #(
    .MAX_VERSIONS(MAX_VERSIONS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .version_i        (version_i),
    .push_value_i     (push_value_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .result_version_o (result_version_o),
    .top_value_o      (top_value_o),
    .depth_o          (depth_o),
    .is_empty_o       (is_empty_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/psk_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module psk_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [9:0]         result_version_o,
  input wire logic signed [31:0] top_value_o,
  input wire logic [9:0]         depth_o,
  input wire logic               is_empty_o,
  input wire logic [1:0]         status_o
);

  import psk_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_version_o) && $stable(top_value_o) && $stable(status_o), "stalled result changed")

  `ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken while busy")

  `ASSERT_IMP(a_err_empty, out_valid_o && (status_o == ST_UNKNOWN || status_o == ST_EMPTY), is_empty_o && depth_o == 10'd0 && top_value_o == 32'sd0, "error result not empty")

endmodule

bind persistent_stack_engine psk_checker u_psk_checker (.*);

`default_nettype wire

// ===== tb/persistent_stack_engine_tb.sv =====
`default_nettype none

module persistent_stack_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psk_pkg::*;

  localparam int unsigned NVER      = 1024;
  localparam logic [10:0] NULL_NODE = 11'd1024;
  localparam int unsigned LIMIT     = 1000000;

  typedef struct packed {
    logic [9:0]         ver;
    logic signed [31:0] top;
    logic [9:0]         dep;
    logic               empty;
    status_e            status;
  } stack_res_t;

  typedef struct {
    mode_e              mode;
    logic [9:0]         ver;
    logic signed [31:0] val;
    int                 gap;
    stack_res_t         res;
  } stack_req_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = 2'd0;
  logic [9:0]         in_version = 10'd0;
  logic signed [31:0] in_push_value = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [9:0]         res_version;
  logic signed [31:0] res_top;
  logic [9:0]         res_depth;
  logic               res_empty;
  logic [1:0]         res_status;

  persistent_stack_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (in_mode),
    .version_i       (in_version),
    .push_value_i    (in_push_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_version_o(res_version),
    .top_value_o     (res_top),
    .depth_o         (res_depth),
    .is_empty_o      (res_empty),
    .status_o        (res_status)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow of the version table and node pool
  logic [10:0] head_tab  [0:NVER-1];
  logic [31:0] val_tab   [0:NVER-1];
  logic [10:0] link_tab  [0:NVER-1];
  logic [10:0] depth_tab [0:NVER-1];
  int unsigned ver_cnt = 1;
  int unsigned node_cnt = 0;

  stack_req_t req_q[$];
  stack_res_t result_q[$];
  int         err_cnt = 0;
  int         n_gen = 0;
  int         n_chk = 0;
  int unsigned cyc = 0;

  function automatic stack_res_t mk_res(logic [9:0] v, logic [31:0] t, logic [10:0] d,
                                        status_e st);
    stack_res_t r;
    r.ver    = v;
    r.top    = t;
    r.dep    = d[9:0];
    r.empty  = (d == 11'd0);
    r.status = st;
    return r;
  endfunction

  function automatic stack_res_t report_version(logic [9:0] v, status_e st);
    logic [10:0] h;
    h = head_tab[v];
    if (h >= NULL_NODE) return mk_res(v, 32'd0, 11'd0, st);
    return mk_res(v, val_tab[h], depth_tab[h], st);
  endfunction

  function automatic stack_res_t stack_apply(mode_e m, logic [9:0] v, logic [31:0] x);
    logic [10:0] h;
    logic [10:0] base_dep;
    if (m == MODE_CLEAR) begin
      ver_cnt = 1;
      node_cnt = 0;
      head_tab[0] = NULL_NODE;
      return mk_res(10'd0, 32'd0, 11'd0, ST_OK);
    end
    if (v >= ver_cnt) return mk_res(v, 32'd0, 11'd0, ST_UNKNOWN);
    h = head_tab[v];
    case (m)
      MODE_QUERY: begin
        return report_version(v, (h >= NULL_NODE) ? ST_EMPTY : ST_OK);
      end
      MODE_POP: begin
        if (h >= NULL_NODE) return mk_res(v, 32'd0, 11'd0, ST_EMPTY);
        if (ver_cnt >= NVER) return report_version(v, ST_FULL);
        head_tab[ver_cnt] = link_tab[h];
        ver_cnt++;
        return report_version(10'(ver_cnt - 1), ST_OK);
      end
      default: begin
        if (ver_cnt >= NVER || node_cnt >= NVER) return report_version(v, ST_FULL);
        base_dep = (h >= NULL_NODE) ? 11'd0 : depth_tab[h];
        val_tab[node_cnt]   = x;
        link_tab[node_cnt]  = h;
        depth_tab[node_cnt] = base_dep + 11'd1;
        head_tab[ver_cnt]   = 11'(node_cnt);
        node_cnt++;
        ver_cnt++;
        return report_version(10'(ver_cnt - 1), ST_OK);
      end
    endcase
  endfunction

  // mostly no gap, some short, a few long
  function automatic int gap_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_item(mode_e m, logic [9:0] v, logic [31:0] x);
    stack_req_t rq;
    rq.mode = m;
    rq.ver  = v;
    rq.val  = x;
    rq.gap  = gap_len((n_gen / 64) % 4 == 3);
    rq.res  = stack_apply(m, v, x);
    req_q   = {req_q, rq};
    n_gen++;
  endtask

  function automatic logic [9:0] pick_known();
    if ($urandom_range(0, 1) == 0) return 10'(ver_cnt - 1);
    return 10'($urandom_range(0, ver_cnt - 1));
  endfunction

  task automatic add_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      add_item(MODE_CLEAR, 10'($urandom), $urandom);
    end else if (r < 7 && ver_cnt < NVER) begin
      add_item(mode_e'($urandom_range(0, 2)), 10'($urandom_range(ver_cnt, NVER - 1)),
               $urandom);
    end else if (r < 12) begin
      add_item(mode_e'($urandom_range(0, 3)), 10'($urandom), $urandom);
    end else if (r < 52) begin
      add_item(MODE_PUSH, pick_known(), $urandom);
    end else if (r < 77) begin
      add_item(MODE_POP, pick_known(), $urandom);
    end else begin
      add_item(MODE_QUERY, pick_known(), $urandom);
    end
  endtask

  // driver
  stack_req_t cur_req;
  int         gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) result_q = {result_q, cur_req.res};
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_mode <= cur_req.mode;
          in_version <= cur_req.ver;
          in_push_value <= cur_req.val;
          in_valid <= 1'b1;
          gap_left = cur_req.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  stack_res_t want;
  int         stall_left = 0;

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("persistent_stack_engine: mismatch");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected item: version %0d top %0d depth %0d status %0d", $time,
                   res_version, res_top, res_depth, res_status);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          n_chk++;
          if (res_version !== want.ver) begin
            $display("%0t result_version exp %0d got %0d", $time, want.ver, res_version);
            err_cnt++;
          end
          if (res_top !== want.top) begin
            $display("%0t top_value exp %0d got %0d", $time, want.top, res_top);
            err_cnt++;
          end
          if (res_depth !== want.dep) begin
            $display("%0t depth exp %0d got %0d", $time, want.dep, res_depth);
            err_cnt++;
          end
          if (res_empty !== want.empty) begin
            $display("%0t is_empty exp %0d got %0d", $time, want.empty, res_empty);
            err_cnt++;
          end
          if (res_status !== want.status) begin
            $display("%0t status exp %0d got %0d", $time, want.status, res_status);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = gap_len((cyc / 700) % 5 == 2);
      end
    end
  end

  initial begin
    head_tab[0] = NULL_NODE;

    // directed
    add_item(MODE_QUERY, 10'd0, 32'd0);
    add_item(MODE_POP, 10'd0, 32'hffffffff);
    add_item(MODE_PUSH, 10'd0, 32'h7fffffff);
    add_item(MODE_PUSH, 10'd1, 32'h80000000);
    add_item(MODE_PUSH, 10'd0, 32'hffffffff);
    add_item(MODE_QUERY, 10'd2, 32'd0);
    add_item(MODE_POP, 10'd2, 32'd0);
    add_item(MODE_POP, 10'd4, 32'd0);
    add_item(MODE_QUERY, 10'd5, 32'd0);
    add_item(MODE_PUSH, 10'd5, 32'd0);
    add_item(MODE_QUERY, 10'd1023, 32'd0);
    add_item(MODE_PUSH, 10'd1023, 32'h5a5a5a5a);
    add_item(MODE_POP, 10'd7, 32'd0);
    add_item(MODE_QUERY, 10'd6, 32'd0);
    add_item(MODE_QUERY, 10'd3, 32'd0);
    add_item(MODE_CLEAR, 10'd1023, 32'hffffffff);
    add_item(MODE_QUERY, 10'd1, 32'd0);
    add_item(MODE_QUERY, 10'd0, 32'd0);
    add_item(MODE_PUSH, 10'd0, 32'h12345678);
    add_item(MODE_POP, 10'd1, 32'd0);
    add_item(MODE_CLEAR, 10'd0, 32'd0);

    repeat (570) add_random();

    add_item(MODE_CLEAR, 10'($urandom), $urandom);
    add_item(MODE_QUERY, 10'd0, 32'd0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_chk < n_gen) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("persistent_stack_engine: match");
    end else begin
      $display("persistent_stack_engine: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== persistent_stack_engine.f =====
+incdir+hw/rtl
hw/rtl/psk_pkg.sv
hw/rtl/psk_ram.sv
hw/rtl/psk_ctrl.sv
hw/rtl/psk_dpath.sv
hw/rtl/persistent_stack_engine.sv
hw/rtl/psk_checker.sv
tb/persistent_stack_engine_tb.sv
